### hdl/ptss_pkg.sv
// Shared types and constants for the periodic task slot scheduler.
// Depends on nothing; used by ptss_cell and the top level.
package ptss_pkg;

	localparam int SLOT_W = 6;
	localparam int KEY_W  = 16;
	localparam int ARG_W  = 32;
	localparam int TICK_W = 32;

	// request command codes as they arrive on the input channel
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_ADD   = 3'd1;
	localparam logic [2:0] CMD_DEL   = 3'd2;
	localparam logic [2:0] CMD_PAUSE = 3'd3;
	localparam logic [2:0] CMD_CONT  = 3'd4;

	// result status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_NOKEY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	// decoded operation carried along the cell chain
	typedef enum logic [2:0] {
		OP_TICK,
		OP_ADD,
		OP_DEL,
		OP_PAUSE,
		OP_CONT,
		OP_IGNORE,
		OP_BADKEY
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// request broadcast to every cell
	typedef struct packed {
		op_t                op;
		logic [KEY_W-1:0]   key;
		logic [ARG_W-1:0]   arg;
		logic [TICK_W-1:0]  period;
		logic [TICK_W-1:0]  tick;
	} req_t;

	// firing report from a cell, all zero when the cell does not fire
	typedef struct packed {
		logic               vld;
		logic [SLOT_W-1:0]  slot;
		logic [KEY_W-1:0]   key;
		logic [ARG_W-1:0]   arg;
	} fire_t;

endpackage

### hdl/ptss_cell.sv
// One task slot of the scheduler chain: holds the slot fields and acts when
// the scan token passes through it. Depends on ptss_pkg.
module ptss_cell import ptss_pkg::*; #(
	parameter logic [SLOT_W-1:0] IDX = '0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  tok_in,
	input  logic  fnd_in,
	input  req_t  req,
	output logic  tok_q,
	output logic  fnd_q,
	output fire_t fire
);

	logic              en_q;
	logic              hr_q;
	logic [KEY_W-1:0]  key_q;
	logic [ARG_W-1:0]  arg_q;
	logic [TICK_W-1:0] period_q;
	logic [TICK_W-1:0] stamp_q;

	logic              act;
	logic [TICK_W-1:0] elapsed;
	logic              due;
	logic              match;
	logic              free;
	logic              hit;

	always_comb begin
		act     = tok_in & adv;
		elapsed = req.tick - stamp_q;
		due     = en_q & (~hr_q | (elapsed >= period_q));
		match   = ~fnd_in & (key_q == req.key);
		free    = ~fnd_in & ~en_q;
		case (req.op)
			OP_ADD:                   hit = free;
			OP_DEL, OP_PAUSE, OP_CONT: hit = match;
			default:                  hit = 1'b0;
		endcase
		fire = '0;
		if (act && req.op == OP_TICK && due) begin
			fire.vld  = 1'b1;
			fire.slot = IDX;
			fire.key  = key_q;
			fire.arg  = arg_q;
		end
	end

	// pass the token and the found flag one cell on per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			fnd_q <= 1'b0;
		end else if (adv) begin
			tok_q <= tok_in;
			fnd_q <= fnd_in | (tok_in & hit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			hr_q     <= 1'b0;
			key_q    <= '0;
			arg_q    <= '0;
			period_q <= '0;
			stamp_q  <= '0;
		end else if (act) begin
			case (req.op)
				OP_TICK: begin
					if (due) begin
						stamp_q <= req.tick;
						hr_q    <= 1'b1;
					end
				end
				OP_ADD: begin
					if (free) begin
						en_q     <= 1'b1;
						hr_q     <= 1'b0;
						key_q    <= req.key;
						arg_q    <= req.arg;
						period_q <= req.period;
						stamp_q  <= '0;
					end
				end
				OP_DEL: begin
					if (match) begin
						en_q     <= 1'b0;
						hr_q     <= 1'b0;
						key_q    <= '0;
						arg_q    <= '0;
						period_q <= '0;
						stamp_q  <= '0;
					end
				end
				OP_PAUSE: begin
					if (match) begin
						en_q <= 1'b0;
					end
				end
				OP_CONT: begin
					if (match) begin
						en_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/periodic_task_slot_scheduler_top.sv
// Periodic task slot scheduler: a chain of SLOTS task cells scanned by a
// traveling token. An accepted request launches a token into cell 0; the
// token moves one cell per cycle while the output register can take data.
// The token runs the whole chain for every request, and the next request
// is taken only after the final result of the previous one has been handed
// to the output register. The scan and the final result wait while the
// output register is full. Each cell holds one slot; add, delete, pause
// and continue act on the first cell that qualifies, and a tick fires every
// due cell in slot order. Firings are held one deep so the last one can be
// marked with tlast. The tick counter advances once the final result of a
// tick has been handed to the output register. Depends on ptss_pkg and
// ptss_cell.
module periodic_task_slot_scheduler_top import ptss_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // task_key[15:0], task_arg[47:16], period_ticks[79:48]
	input  logic [2:0]  s_tuser,   // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // status[1:0], fired_slot[7:2], fired_key[23:8],
	                               // fired_arg[55:24]
	output logic        m_tuser,   // fired
	output logic        m_tlast
);

	state_t state_q;
	state_t state_d;

	req_t              req_q;
	logic [TICK_W-1:0] tick_q;
	logic              start_q;
	logic              found_q;

	// one-deep hold of the most recent firing of a tick scan
	logic              pend_vld_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [KEY_W-1:0]  pend_key_q;
	logic [ARG_W-1:0]  pend_arg_q;

	// output register
	logic              ovalid_q;
	logic [1:0]        ostatus_q;
	logic              ofired_q;
	logic [SLOT_W-1:0] oslot_q;
	logic [KEY_W-1:0]  okey_q;
	logic [ARG_W-1:0]  oarg_q;
	logic              olast_q;

	logic              accept;
	logic              out_free;
	logic              adv;
	logic              fin_load;
	op_t               op_dec;
	req_t              req_bus;
	logic [1:0]        fin_status;

	logic [SLOTS:0]    tok_chain;
	logic [SLOTS:0]    fnd_chain;
	fire_t             fire_or [SLOTS+1];
	logic [SLOTS-1:0]  tok_vec;
	fire_t             fire_any;

	assign out_free = ~ovalid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	// decode the command; a zero key on a slot command is rejected outright
	always_comb begin
		unique case (s_tuser)
			CMD_TICK:  op_dec = OP_TICK;
			CMD_ADD:   op_dec = OP_ADD;
			CMD_DEL:   op_dec = OP_DEL;
			CMD_PAUSE: op_dec = OP_PAUSE;
			CMD_CONT:  op_dec = OP_CONT;
			default:   op_dec = OP_IGNORE;
		endcase
		if (op_dec != OP_TICK && op_dec != OP_IGNORE && s_tdata[15:0] == '0) begin
			op_dec = OP_BADKEY;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (adv && tok_chain[SLOTS]) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		adv      = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_SCAN:   adv      = out_free;
			ST_FINISH: fin_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the request and launch the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			found_q <= 1'b0;
			tick_q  <= '0;
		end else begin
			if (accept) begin
				start_q <= 1'b1;
			end else if (adv) begin
				start_q <= 1'b0;
			end
			if (adv && tok_chain[SLOTS]) begin
				found_q <= fnd_chain[SLOTS];
			end
			if (fin_load && req_q.op == OP_TICK) begin
				tick_q <= tick_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.op     <= op_dec;
			req_q.key    <= s_tdata[15:0];
			req_q.arg    <= s_tdata[47:16];
			req_q.period <= s_tdata[79:48];
			req_q.tick   <= '0;
		end
	end

	always_comb begin
		req_bus      = req_q;
		req_bus.tick = tick_q;
	end

	// cell chain
	assign tok_chain[0] = start_q;
	assign fnd_chain[0] = 1'b0;
	assign fire_or[0]   = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		fire_t fire_c;
		ptss_cell #(
			.IDX(SLOT_W'(i))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.tok_in (tok_chain[i]),
			.fnd_in (fnd_chain[i]),
			.req    (req_bus),
			.tok_q  (tok_chain[i+1]),
			.fnd_q  (fnd_chain[i+1]),
			.fire   (fire_c)
		);
		// only the cell holding the token can report, so an OR merges them
		assign fire_or[i+1] = fire_or[i] | fire_c;
	end

	assign tok_vec  = tok_chain[SLOTS:1];
	assign fire_any = fire_or[SLOTS];

	// final status of the request
	always_comb begin
		case (req_q.op)
			OP_ADD:                   fin_status = found_q ? STS_OK : STS_FULL;
			OP_DEL, OP_PAUSE, OP_CONT: fin_status = found_q ? STS_OK : STS_NOKEY;
			OP_BADKEY:                fin_status = STS_NOKEY;
			default:                  fin_status = STS_OK;
		endcase
	end

	// hold the latest firing; push the previous one out when a new one comes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (adv && fire_any.vld) begin
			pend_vld_q <= 1'b1;
		end else if (fin_load) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fire_any.vld) begin
			pend_slot_q <= fire_any.slot;
			pend_key_q  <= fire_any.key;
			pend_arg_q  <= fire_any.arg;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((adv && fire_any.vld && pend_vld_q) || fin_load) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fire_any.vld && pend_vld_q) begin
			ostatus_q <= STS_OK;
			ofired_q  <= 1'b1;
			oslot_q   <= pend_slot_q;
			okey_q    <= pend_key_q;
			oarg_q    <= pend_arg_q;
			olast_q   <= 1'b0;
		end else if (fin_load) begin
			ostatus_q <= fin_status;
			ofired_q  <= pend_vld_q;
			oslot_q   <= pend_vld_q ? pend_slot_q : '0;
			okey_q    <= pend_vld_q ? pend_key_q : '0;
			oarg_q    <= pend_vld_q ? pend_arg_q : '0;
			olast_q   <= 1'b1;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {oarg_q, okey_q, oslot_q, ostatus_q};
	assign m_tuser  = ofired_q;
	assign m_tlast  = olast_q;

`ifndef SYNTHESIS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_vec, start_q}))
		else $error("more than one scan token in the cell chain");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (tok_vec == '0) && !start_q && !pend_vld_q)
		else $error("chain or held firing busy while idle");

	a_fire_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire_any.vld |-> adv && req_q.op == OP_TICK)
		else $error("firing reported outside a tick scan");

	a_tick_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load && req_q.op == OP_TICK |=> tick_q == $past(tick_q) + 1'b1)
		else $error("tick counter did not advance after a tick");
`endif

endmodule
